>>> design/vahl_pkg.sv
package vahl_pkg;

  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] RegHrAlarmHigh  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSpo2AlarmLow = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHrClearHigh  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSpo2ClearLow = 3'd3;
  localparam logic [CfgIdxW-1:0] RegClearRunLen  = 3'd4;

  localparam logic [7:0] HrAlarmHighRst  = 8'd180;
  localparam logic [6:0] Spo2AlarmLowRst = 7'd90;
  localparam logic [7:0] HrClearHighRst  = 8'd175;
  localparam logic [6:0] Spo2ClearLowRst = 7'd93;
  localparam logic [3:0] ClearRunLenRst  = 4'd3;

  localparam logic [3:0] RunMax = 4'd15;

  typedef struct packed {
    logic [5:0] device_index;
    logic       fall_flag;
    logic [7:0] hr_bpm;
    logic [6:0] spo2;
  } in_item_t;

  typedef struct packed {
    logic [5:0] event_device;
    logic       fall_alarm;
    logic       vital_alarm;
    logic       vital_cleared;
  } out_item_t;

  typedef struct packed {
    logic [7:0] hr_alarm_high;
    logic [6:0] spo2_alarm_low;
    logic [7:0] hr_clear_high;
    logic [6:0] spo2_clear_low;
    logic [3:0] clear_run_length;
  } cfg_t;

  typedef struct packed {
    logic       fall_latched;
    logic       vital_latched;
    logic [3:0] normal_run;
  } dev_state_t;

  localparam int unsigned StateW = $bits(dev_state_t);

endpackage

>>> design/vahl_ram.sv
module vahl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/vahl_update.sv
module vahl_update (
  input  vahl_pkg::cfg_t       cfg_i,
  input  vahl_pkg::in_item_t   item_i,
  input  logic                 in_range_i,
  input  vahl_pkg::dev_state_t cur_i,
  output vahl_pkg::dev_state_t nxt_o,
  output vahl_pkg::out_item_t  res_o
);

  logic       hr_ok, sp_ok, abnormal, normal;
  logic [3:0] run_inc;

  always_comb begin
    hr_ok    = item_i.hr_bpm != 8'd0;
    sp_ok    = item_i.spo2 != 7'd0;
    abnormal = (hr_ok && (item_i.hr_bpm > cfg_i.hr_alarm_high)) ||
               (sp_ok && (item_i.spo2 < cfg_i.spo2_alarm_low));
    normal   = (!hr_ok || (item_i.hr_bpm <= cfg_i.hr_clear_high)) &&
               (!sp_ok || (item_i.spo2 >= cfg_i.spo2_clear_low));
    run_inc  = (cur_i.normal_run < vahl_pkg::RunMax) ? cur_i.normal_run + 4'd1
                                                     : cur_i.normal_run;

    nxt_o              = cur_i;
    res_o.event_device = item_i.device_index;
    res_o.fall_alarm   = 1'b0;
    res_o.vital_alarm  = 1'b0;
    res_o.vital_cleared = 1'b0;

    if (item_i.fall_flag) begin
      nxt_o.fall_latched = 1'b1;
      res_o.fall_alarm   = !cur_i.fall_latched;
    end else begin
      nxt_o.fall_latched = 1'b0;
    end

    if (abnormal) begin
      nxt_o.normal_run    = 4'd0;
      nxt_o.vital_latched = 1'b1;
      res_o.vital_alarm   = !cur_i.vital_latched;
    end else if (normal && cur_i.vital_latched) begin
      if (run_inc >= cfg_i.clear_run_length) begin
        nxt_o.normal_run    = 4'd0;
        nxt_o.vital_latched = 1'b0;
        res_o.vital_cleared = 1'b1;
      end else begin
        nxt_o.normal_run = run_inc;
      end
    end

    if (!in_range_i) begin
      res_o.fall_alarm    = 1'b0;
      res_o.vital_alarm   = 1'b0;
      res_o.vital_cleared = 1'b0;
    end
  end

endmodule

>>> design/vital_alarm_hysteresis_latch.sv
// Accepted items are registered in stage s1, then in the output register
// behind out_valid_o. Throughput: one transaction per cycle while in_stall_o
// is low; per-device state lives in one RAM, read on acceptance and written
// back as s1 advances, with forwarding. Reset: thresholds return to defaults,
// then a clearing pass writes every RAM entry to zero, holding in_stall_o high.
module vital_alarm_hysteresis_latch #(
  parameter int unsigned DEVICE_COUNT = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  vahl_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output vahl_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [vahl_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [vahl_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  localparam int unsigned AW = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int unsigned XW = (AW > 6) ? AW : 6;

  vahl_pkg::cfg_t       cfg_q;
  logic                 clr_busy_q;
  logic [AW-1:0]        clr_addr_q;

  logic                 s1_valid_q, s1_range_q, s1_hit_q;
  vahl_pkg::in_item_t   s1_item_q;
  logic [AW-1:0]        s1_addr_q;
  vahl_pkg::dev_state_t fwd_q;

  logic                 out_valid_q;
  vahl_pkg::out_item_t  out_data_q;

  logic                 in_accept, s1_adv, upd_we, in_range;
  logic [AW-1:0]        in_addr;
  logic [XW-1:0]        in_dev_ext;
  vahl_pkg::dev_state_t rd_state, cur_state, nxt_state;
  vahl_pkg::out_item_t  res;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [vahl_pkg::StateW-1:0] ram_wdata, ram_rdata;

  assign in_dev_ext = XW'(in_data_i.device_index);
  assign in_addr    = in_dev_ext[AW-1:0];
  assign in_range   = 32'(in_data_i.device_index) < DEVICE_COUNT;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_busy_q || (s1_valid_q && !s1_adv);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign upd_we     = s1_valid_q && s1_adv && s1_range_q;

  assign rd_state  = vahl_pkg::dev_state_t'(ram_rdata);
  assign cur_state = s1_hit_q ? fwd_q : rd_state;

  vahl_update u_update (
    .cfg_i      (cfg_q),
    .item_i     (s1_item_q),
    .in_range_i (s1_range_q),
    .cur_i      (cur_state),
    .nxt_o      (nxt_state),
    .res_o      (res)
  );

  assign ram_we    = clr_busy_q || upd_we;
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_busy_q ? '0 : nxt_state;

  vahl_ram #(
    .WIDTH (vahl_pkg::StateW),
    .DEPTH (DEVICE_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hr_alarm_high    <= vahl_pkg::HrAlarmHighRst;
      cfg_q.spo2_alarm_low   <= vahl_pkg::Spo2AlarmLowRst;
      cfg_q.hr_clear_high    <= vahl_pkg::HrClearHighRst;
      cfg_q.spo2_clear_low   <= vahl_pkg::Spo2ClearLowRst;
      cfg_q.clear_run_length <= vahl_pkg::ClearRunLenRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vahl_pkg::RegHrAlarmHigh:  cfg_q.hr_alarm_high    <= cfg_wdata_i;
        vahl_pkg::RegSpo2AlarmLow: cfg_q.spo2_alarm_low   <= cfg_wdata_i[6:0];
        vahl_pkg::RegHrClearHigh:  cfg_q.hr_clear_high    <= cfg_wdata_i;
        vahl_pkg::RegSpo2ClearLow: cfg_q.spo2_clear_low   <= cfg_wdata_i[6:0];
        vahl_pkg::RegClearRunLen:  cfg_q.clear_run_length <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(DEVICE_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        s1_hit_q   <= upd_we && (s1_addr_q == in_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q  <= in_data_i;
      s1_addr_q  <= in_addr;
      s1_range_q <= in_range;
    end
    if (upd_we) begin
      fwd_q <= nxt_state;
    end
    if (s1_valid_q && s1_adv) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
